>>> rtl/ppc_pkg.sv
// Shared constants, types and codes of the palette pixel compositor.
// Used by every module of the block; depends on nothing else.
package ppc_pkg;

	localparam int PALETTE_DEPTH = 512;
	localparam int SCREEN_WIDTH = 640;

	localparam int IDX_W = 9;
	localparam int PAL_AW = $clog2(PALETTE_DEPTH);
	localparam int ROW_W = 9;
	localparam int COL_W = 10;
	localparam int LAYER_W = 3;
	localparam int CHAN_W = 8;
	localparam int SRC_W = 5;
	localparam int WORD_W = 15;
	localparam int TYPE_W = 2;
	localparam int SCR_W = 12;

	localparam int FADE_W = 8;
	localparam int MASK_W = 16;
	localparam int EDGE_W = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam int IN_DATA_W = 72;
	localparam int OUT_DATA_W = 48;

	localparam logic [TYPE_W-1:0] REQ_PAL_WRITE = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_DRAW = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_ADD = 2'd2;
	localparam logic [TYPE_W-1:0] REQ_SUB = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_FADE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_MASK = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEFT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_RIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = 3'd4;

	localparam logic [FADE_W-1:0] FADE_AMOUNT_MASK = 8'h1F;
	localparam logic [FADE_W-1:0] FADE_BRIGHTEN = 8'h80;
	localparam logic [SRC_W:0] CHAN_MAX = 6'd31;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb8_t;

	typedef struct packed {
		logic [TYPE_W-1:0] mode;
		logic [FADE_W-1:0] fade;
	} shade_ctrl_t;

endpackage

>>> rtl/ppc_palette_ram.sv
// Palette memory: one write port, one read port, registered read data.
// Depends on ppc_pkg for depth and word width.
module ppc_palette_ram (
	input  logic                       clk,
	input  logic                       wen,
	input  logic [ppc_pkg::PAL_AW-1:0] waddr,
	input  logic [ppc_pkg::WORD_W-1:0] wdata,
	input  logic                       ren,
	input  logic [ppc_pkg::PAL_AW-1:0] raddr,
	output logic [ppc_pkg::WORD_W-1:0] rdata
);

	logic [ppc_pkg::WORD_W-1:0] mem [ppc_pkg::PALETTE_DEPTH];

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ren) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/ppc_shade.sv
// Color path: fade of each 5-bit channel, expansion to 8 bits and blend
// with the destination pixel. Depends on ppc_pkg.
module ppc_shade (
	input  logic                       clk,
	input  ppc_pkg::shade_ctrl_t       ctrl,
	input  logic [ppc_pkg::WORD_W-1:0] src_word,
	input  ppc_pkg::rgb8_t             dest,
	output ppc_pkg::rgb8_t             result
);

	function automatic logic [ppc_pkg::SRC_W-1:0] fade_chan(
		input logic [ppc_pkg::SRC_W-1:0] c,
		input logic [ppc_pkg::FADE_W-1:0] fc
	);
		logic [ppc_pkg::SRC_W-1:0] f;
		logic [ppc_pkg::SRC_W:0] sum;
		f = ppc_pkg::SRC_W'(fc & ppc_pkg::FADE_AMOUNT_MASK);
		sum = {1'b0, c} + {1'b0, f};
		if (fc == '0) begin
			fade_chan = c;
		end else if ((fc & ppc_pkg::FADE_BRIGHTEN) != '0) begin
			fade_chan = (sum > ppc_pkg::CHAN_MAX) ? ppc_pkg::SRC_W'(ppc_pkg::CHAN_MAX)
				: sum[ppc_pkg::SRC_W-1:0];
		end else begin
			fade_chan = (c < f) ? '0 : c - f;
		end
	endfunction

	function automatic logic [ppc_pkg::CHAN_W-1:0] blend_chan(
		input logic [ppc_pkg::SRC_W-1:0] c,
		input logic [ppc_pkg::CHAN_W-1:0] dst,
		input logic [ppc_pkg::TYPE_W-1:0] mode
	);
		logic [ppc_pkg::CHAN_W-1:0] src;
		logic [ppc_pkg::CHAN_W:0] sum;
		logic [ppc_pkg::CHAN_W-1:0] diff;
		src = {c, c[ppc_pkg::SRC_W-1 -: 3]};
		sum = {1'b0, src} + {1'b0, dst};
		diff = src - dst;
		case (mode)
			ppc_pkg::REQ_ADD: blend_chan = sum[ppc_pkg::CHAN_W:1];
			ppc_pkg::REQ_SUB: blend_chan = (src > dst) ? {1'b0, diff[ppc_pkg::CHAN_W-1:1]} : '0;
			default:          blend_chan = src;
		endcase
	endfunction

	// Faded 5-bit channels are registered before expansion and blend.
	logic [ppc_pkg::SRC_W-1:0] red_s2, green_s2, blue_s2;
	logic [ppc_pkg::TYPE_W-1:0] mode_s2;
	ppc_pkg::rgb8_t dest_s2;

	always_ff @(posedge clk) begin
		red_s2   <= fade_chan(src_word[4:0], ctrl.fade);
		green_s2 <= fade_chan(src_word[9:5], ctrl.fade);
		blue_s2  <= fade_chan(src_word[14:10], ctrl.fade);
		mode_s2  <= ctrl.mode;
		dest_s2  <= dest;
	end

	assign result.red   = blend_chan(red_s2, dest_s2.red, mode_s2);
	assign result.green = blend_chan(green_s2, dest_s2.green, mode_s2);
	assign result.blue  = blend_chan(blue_s2, dest_s2.blue, mode_s2);

endmodule

>>> rtl/palette_pixel_compositor.sv
// Top level of the palette pixel compositor: handshake, window test and
// pipeline control. Depends on ppc_pkg, ppc_palette_ram and ppc_shade.
//
// The block takes one word per clock while the output side is not stalled
// and returns one result word for each input word, in order. A word passes
// the palette read, the fade stage and the blend into the output register.
// The palette memory has one write port and one read port; since an
// input word either writes or reads the palette, never both, consecutive
// words never contend for it and a read always sees every earlier write.
// Output-side stalls hold each occupied stage; the palette read data holds too.
module palette_pixel_compositor (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [ppc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ppc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// color_index, pixel_row, pixel_column, layer_id, dest_blue, dest_green,
	// dest_red, palette_word, then zero fill
	input  logic [ppc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// req_type
	input  logic [ppc_pkg::TYPE_W-1:0]          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// out_row, out_column, out_blue, out_green, out_red, then zero fill
	output logic [ppc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// write_enable
	output logic                                m_axis_tuser
);

	typedef struct packed {
		logic [ppc_pkg::TYPE_W-1:0] mode;
		logic                       draw;
		logic                       visible;
		logic                       use_pal;
		logic [ppc_pkg::ROW_W-1:0]  row;
		logic [ppc_pkg::COL_W-1:0]  col;
		ppc_pkg::rgb8_t             dest;
	} item_t;

	// Configuration registers.
	logic [ppc_pkg::FADE_W-1:0] fade_q;
	logic [ppc_pkg::MASK_W-1:0] mask_q;
	logic [ppc_pkg::EDGE_W-1:0] left_q, right_q;
	logic                       half_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_q  <= '0;
			mask_q  <= '0;
			left_q  <= '0;
			right_q <= '0;
			half_q  <= 1'b0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				ppc_pkg::CFG_FADE:       fade_q  <= cfg_wdata[ppc_pkg::FADE_W-1:0];
				ppc_pkg::CFG_WIN_MASK:   mask_q  <= cfg_wdata[ppc_pkg::MASK_W-1:0];
				ppc_pkg::CFG_WIN_LEFT:   left_q  <= cfg_wdata[ppc_pkg::EDGE_W-1:0];
				ppc_pkg::CFG_WIN_RIGHT:  right_q <= cfg_wdata[ppc_pkg::EDGE_W-1:0];
				ppc_pkg::CFG_HALF_WIDTH: half_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Input unpacking.
	logic [ppc_pkg::TYPE_W-1:0]  in_type;
	logic [ppc_pkg::IDX_W-1:0]   in_idx;
	logic [ppc_pkg::ROW_W-1:0]   in_row;
	logic [ppc_pkg::COL_W-1:0]   in_col;
	logic [ppc_pkg::LAYER_W-1:0] in_layer;
	ppc_pkg::rgb8_t              in_dest;
	logic [ppc_pkg::WORD_W-1:0]  in_word;

	assign in_type       = s_axis_tuser;
	assign in_idx        = s_axis_tdata[8:0];
	assign in_row        = s_axis_tdata[17:9];
	assign in_col        = s_axis_tdata[27:18];
	assign in_layer      = s_axis_tdata[30:28];
	assign in_dest.blue  = s_axis_tdata[38:31];
	assign in_dest.green = s_axis_tdata[46:39];
	assign in_dest.red   = s_axis_tdata[54:47];
	assign in_word       = s_axis_tdata[69:55];

	// Pipeline control.
	logic v1_q, v2_q, out_valid_q;
	logic adv_out, adv2, adv1, accept;

	assign adv_out       = !out_valid_q || m_axis_tready;
	assign adv2          = !v2_q || adv_out;
	assign adv1          = !v1_q || adv2;
	assign s_axis_tready = adv1;
	assign accept        = s_axis_tvalid && adv1;

	// Palette address and range check.
	logic [ppc_pkg::IDX_W:0]    idx_ext;
	logic                       idx_ok;
	logic [ppc_pkg::PAL_AW-1:0] ram_addr;
	logic [ppc_pkg::WORD_W-1:0] pal_q;
	logic                       is_write;

	assign idx_ext  = {1'b0, in_idx};
	assign idx_ok   = idx_ext < (ppc_pkg::IDX_W + 1)'(ppc_pkg::PALETTE_DEPTH);
	assign ram_addr = idx_ext[ppc_pkg::PAL_AW-1:0];
	assign is_write = in_type == ppc_pkg::REQ_PAL_WRITE;

	ppc_palette_ram u_pal (
		.clk   (clk),
		.wen   (accept && is_write && idx_ok),
		.waddr (ram_addr),
		.wdata (in_word),
		.ren   (accept && !is_write),
		.raddr (ram_addr),
		.rdata (pal_q)
	);

	// Window test on the incoming word.
	logic [ppc_pkg::COL_W:0] col_ext, left_ext, right_ext;
	logic                    on_screen, in_window, clip, clip_out, clip_in;

	assign col_ext   = {1'b0, in_col};
	assign left_ext  = half_q ? {left_q, 1'b0} : {1'b0, left_q};
	assign right_ext = half_q ? {right_q, 1'b0} : {1'b0, right_q};
	assign on_screen = {{(ppc_pkg::SCR_W - ppc_pkg::COL_W){1'b0}}, in_col}
		< ppc_pkg::SCR_W'(ppc_pkg::SCREEN_WIDTH);
	assign in_window = (col_ext >= left_ext) && (col_ext <= right_ext);
	assign clip_out  = mask_q[in_layer] && !in_window;
	assign clip_in   = mask_q[in_layer + ppc_pkg::LAYER_W'(0) + 4'd8] && in_window;
	assign clip      = (mask_q != '0) && (clip_out || clip_in);

	item_t item_d, s1_q, s2_q;

	always_comb begin
		item_d.mode    = in_type;
		item_d.draw    = !is_write;
		// Layer zero still draws, from a black source color; other clipped layers drop out.
		item_d.visible = on_screen && !(clip && in_layer != '0);
		item_d.use_pal = idx_ok && !clip && !is_write;
		item_d.row     = in_row;
		item_d.col     = in_col;
		item_d.dest    = in_dest;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv1) begin
				v1_q <= s_axis_tvalid;
			end
			if (adv2) begin
				v2_q <= v1_q;
			end
			if (adv_out) begin
				out_valid_q <= v2_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q <= item_d;
		end
		if (adv2) begin
			s2_q <= s1_q;
		end
	end

	// The shade unit's internal register moves with stage two.
	ppc_pkg::shade_ctrl_t shade_ctrl;
	logic [ppc_pkg::WORD_W-1:0] src_word;
	ppc_pkg::rgb8_t shade_rgb, shade_dest;

	assign shade_ctrl.mode = s1_q.mode;
	assign shade_ctrl.fade = fade_q;
	assign src_word        = s1_q.use_pal ? pal_q : '0;

	logic [ppc_pkg::WORD_W-1:0] src_hold_q;
	ppc_pkg::shade_ctrl_t       ctrl_hold_q;
	ppc_pkg::rgb8_t             dest_hold_q;

	// Present stage-one values to the shade unit only when stage two loads,
	// so its register keeps the stalled word.
	always_ff @(posedge clk) begin
		if (adv2) begin
			src_hold_q  <= src_word;
			ctrl_hold_q <= shade_ctrl;
			dest_hold_q <= s1_q.dest;
		end
	end

	ppc_shade u_shade (
		.clk      (clk),
		.ctrl     (adv2 ? shade_ctrl : ctrl_hold_q),
		.src_word (adv2 ? src_word : src_hold_q),
		.dest     (adv2 ? s1_q.dest : dest_hold_q),
		.result   (shade_rgb)
	);

	assign shade_dest = s2_q.dest;

	// Output register.
	logic                      out_we_q;
	logic [ppc_pkg::ROW_W-1:0] out_row_q;
	logic [ppc_pkg::COL_W-1:0] out_col_q;
	ppc_pkg::rgb8_t            out_rgb_q;

	always_ff @(posedge clk) begin
		if (adv_out) begin
			out_we_q  <= s2_q.draw && s2_q.visible;
			out_row_q <= s2_q.draw ? s2_q.row : '0;
			out_col_q <= s2_q.draw ? s2_q.col : '0;
			out_rgb_q <= (s2_q.draw && s2_q.visible) ? shade_rgb : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_we_q;
	assign m_axis_tdata  = {5'd0, out_rgb_q.red, out_rgb_q.green, out_rgb_q.blue,
		out_col_q, out_row_q};

	// Checks.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v1_q)
		else $error("accepted word did not reach stage one");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q && !adv2 |=> v1_q && $stable(s1_q) && (!s1_q.use_pal || $stable(pal_q)))
		else $error("stalled stage one or palette data changed");

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v2_q && !adv_out |=> v2_q && $stable(s2_q) && $stable(shade_rgb))
		else $error("stalled stage two changed");

	a_no_write_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_we_q |-> out_rgb_q == '0)
		else $error("suppressed word carries color");

	a_unused_dest: assert property (@(posedge clk) disable iff (!arst_n)
		v2_q && s2_q.mode == ppc_pkg::REQ_DRAW && s2_q.visible && s2_q.draw
		|-> shade_dest == s2_q.dest)
		else $error("destination pixel out of step");

endmodule
